>>> src/double_ended_queue_top_macros.svh
// Assertion macros used by the double-ended queue top level.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk and held off during reset.
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DQ_ASSERT_NOW(label, ante, cons, msg)
`define DQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> src/dq_pkg.sv
// Shared constants, payload types and control structs of the double-ended queue.
`default_nettype none

package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_PUSH_REAR  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        mode_t                         mode;
        logic signed [DATA_WIDTH-1:0]  push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  popped_value;
        status_t                       status;
        logic        [CNT_W-1:0]       entry_count;
        logic signed [DATA_WIDTH-1:0]  front_value;
        logic signed [DATA_WIDTH-1:0]  rear_value;
        logic                          is_empty;
    } rsp_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } dq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic finish;
    } dq_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic needs_read;
    } dq_stat_t;

endpackage

`default_nettype wire

>>> src/dq_ctrl.sv
// Controller state machine of the double-ended queue.
`default_nettype none

module dq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_ctl_t      ctl
);

    dq_pkg::dq_state_t state_reg;
    dq_pkg::dq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A pop that leaves one or more words needs the new end word from memory.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                if (cmd_valid && stat.out_free && stat.needs_read)
                begin
                    state_next = dq_pkg::S_READ;
                end
            end
            dq_pkg::S_READ:
            begin
                state_next = dq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_stall  = 1'b1;
        ctl.accept = 1'b0;
        ctl.finish = 1'b0;
        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                cmd_stall  = !stat.out_free;
                ctl.accept = cmd_valid && stat.out_free;
            end
            dq_pkg::S_READ:
            begin
                ctl.finish = 1'b1;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/dq_dpath.sv
// Datapath of the double-ended queue: slot memory, pointers, cached ends and result register.
`default_nettype none

module dq_dpath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dq_pkg::cmd_t     cmd,
    input  wire dq_pkg::dq_ctl_t  ctl,
    output dq_pkg::dq_stat_t      stat,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output dq_pkg::rsp_t          rsp
);

    localparam int IDX_W = dq_pkg::IDX_W;
    localparam int CNT_W = dq_pkg::CNT_W;
    localparam int DW    = dq_pkg::DATA_WIDTH;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(dq_pkg::DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(dq_pkg::DEPTH - 1) : i - IDX_W'(1);
    endfunction

    logic signed [DW-1:0] slot_mem [dq_pkg::DEPTH];

    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic signed [DW-1:0] front_reg, front_next;
    logic signed [DW-1:0] rear_reg, rear_next;
    logic signed [DW-1:0] pend_popped_reg, pend_popped_next;
    logic                 pend_front_reg, pend_front_next;
    logic signed [DW-1:0] rd_data_reg;
    dq_pkg::rsp_t         rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 rsp_load;
    logic signed [DW-1:0] popped;
    dq_pkg::status_t      status;
    logic                 is_full;
    logic                 is_empty;
    logic                 is_pop;
    logic                 many;

    assign is_full  = (count_reg == CNT_W'(dq_pkg::DEPTH));
    assign is_empty = (count_reg == '0);
    assign is_pop   = (cmd.mode == dq_pkg::MODE_POP_FRONT) ||
                      (cmd.mode == dq_pkg::MODE_POP_REAR);
    assign many     = is_pop && (count_reg > CNT_W'(1));

    assign stat = '{out_free: (!rsp_valid_reg || !rsp_stall), needs_read: many};

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        front_next       = front_reg;
        rear_next        = rear_reg;
        pend_popped_next = pend_popped_reg;
        pend_front_next  = pend_front_reg;
        wr_en            = 1'b0;
        wr_addr          = tail_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_inc(head_reg);
        popped           = '0;
        status           = dq_pkg::STATUS_OK;
        rsp_load         = 1'b0;
        if (ctl.accept)
        begin
            case (cmd.mode)
                dq_pkg::MODE_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        status = dq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = tail_reg;
                        tail_next  = idx_inc(tail_reg);
                        count_next = count_reg + CNT_W'(1);
                        rear_next  = cmd.push_value;
                        if (is_empty)
                        begin
                            front_next = cmd.push_value;
                        end
                    end
                end
                dq_pkg::MODE_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status = dq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = idx_dec(head_reg);
                        head_next  = idx_dec(head_reg);
                        count_next = count_reg + CNT_W'(1);
                        front_next = cmd.push_value;
                        if (is_empty)
                        begin
                            rear_next = cmd.push_value;
                        end
                    end
                end
                dq_pkg::MODE_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status = dq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        popped          = front_reg;
                        head_next       = idx_inc(head_reg);
                        count_next      = count_reg - CNT_W'(1);
                        rd_en           = many;
                        rd_addr         = idx_inc(head_reg);
                        pend_front_next = 1'b1;
                    end
                end
                dq_pkg::MODE_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        status = dq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        popped          = rear_reg;
                        tail_next       = idx_dec(tail_reg);
                        count_next      = count_reg - CNT_W'(1);
                        rd_en           = many;
                        rd_addr         = idx_dec(idx_dec(tail_reg));
                        pend_front_next = 1'b0;
                    end
                end
                default:
                begin
                    status = dq_pkg::STATUS_OK;
                end
            endcase
            pend_popped_next = popped;
            rsp_load         = !many;
        end
        else if (ctl.finish)
        begin
            // The memory word read at accept becomes the new end of the queue.
            popped   = pend_popped_reg;
            rsp_load = 1'b1;
            if (pend_front_reg)
            begin
                front_next = rd_data_reg;
            end
            else
            begin
                rear_next = rd_data_reg;
            end
        end
    end

    always_comb
    begin
        rsp_next.popped_value = popped;
        rsp_next.status       = status;
        rsp_next.entry_count  = count_next;
        rsp_next.is_empty     = (count_next == '0);
        rsp_next.front_value  = (count_next == '0) ? '0 : front_next;
        rsp_next.rear_value   = (count_next == '0) ? '0 : rear_next;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg       <= front_next;
        rear_reg        <= rear_next;
        pend_popped_reg <= pend_popped_next;
        pend_front_reg  <= pend_front_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= cmd.push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> src/double_ended_queue_top.sv
// Top level of the double-ended queue: controller, datapath and checks.
//
//  Channel | Signals                      | Direction | Payload
//  --------+------------------------------+-----------+------------------------
//  cmd     | cmd_valid, cmd_stall, cmd    | in        | mode, push_value
//  rsp     | rsp_valid, rsp_stall, rsp    | out       | popped_value, status,
//          |                              |           | entry_count, front_value,
//          |                              |           | rear_value, is_empty
//
// A push, a failed pop, or a pop that empties the queue loads its result at accept.
// A pop that leaves one or more words also passes through the read state: the new end word is
// read from the slot memory, whose read data is registered.
// Reset clears the pointers, the count and the result valid, not the slots.
// A command transfer is taken while the result register is empty or drains
// in the same cycle, so a stall on rsp holds back cmd.
`default_nettype none

`include "double_ended_queue_top_macros.svh"

module double_ended_queue_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire dq_pkg::cmd_t  cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output dq_pkg::rsp_t       rsp
);

    // Commands and status between the controller and the datapath.
    dq_pkg::dq_ctl_t  ctl;
    dq_pkg::dq_stat_t stat;

    // The controller sequences each operation: it accepts in idle, and passes
    // through the read state when a pop must fetch the next end word from memory.
    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // The datapath keeps the slot memory, the head and tail pointers, the
    // count, cached copies of the front and rear words, and the result register.
    dq_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // A command transfer happens only when the result register can take its result.
    `DQ_ASSERT_NOW(a_cmd_needs_room, cmd_valid && !cmd_stall,
        !rsp_valid || !rsp_stall, "command transfer while result register blocked")

    // A refused push is reported only when the queue is full.
    `DQ_ASSERT_NOW(a_full_count, rsp_valid && (rsp.status == dq_pkg::STATUS_FULL),
        rsp.entry_count == dq_pkg::CNT_W'(dq_pkg::DEPTH), "full status with a low count")

    // An empty queue shows zero at both ends.
    `DQ_ASSERT_NOW(a_empty_ends, rsp_valid && rsp.is_empty,
        (rsp.front_value == '0) && (rsp.rear_value == '0) && (rsp.entry_count == '0),
        "empty result with nonzero ends or count")

    // A pop that needs a memory read holds off the next command while the controller is in the read state.
    `DQ_ASSERT_NEXT(a_read_blocks, ctl.accept && stat.needs_read,
        cmd_stall && ctl.finish, "read cycle missing after a multi-word pop")

endmodule

`default_nettype wire
